FILE: rtl/keyframe_track_interpolator_unit_macros.svh
// Assertion macros used by the keyframe track interpolator controller.
// No dependencies; the macros expect clk and rst_n in the including scope.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_UNIT_MACROS_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define KTI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kti assertion failed");
// Next-cycle implication, disabled during reset
`define KTI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kti assertion failed");
`else
`define KTI_ASSERT_IMP(label, ante, cons)
`define KTI_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: rtl/kti_pkg.sv
// Package for the keyframe track interpolator: field widths, codes,
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package kti_pkg;

  localparam int DATA_W     = 32;
  localparam int KEY_IDX_W  = 6;
  localparam int SLOT_W     = 2;
  localparam int COMP_W     = 3;
  localparam int MODE_W     = 2;
  localparam int KCNT_W     = 7;
  localparam int CCNT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int MAX_KEYS_DEF       = 64;
  localparam int MAX_COMPONENTS_DEF = 8;
  localparam int WORD_SLOTS         = 3;
  localparam int Q_ONE              = 65536;

  // Input operations
  localparam logic [1:0] OP_WR_TIME = 2'd0;
  localparam logic [1:0] OP_WR_WORD = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  // Value word kinds
  localparam logic [SLOT_W-1:0] SLOT_IN  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_VAL = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_OUT = 2'd2;

  // Interpolation modes (code 3 runs as linear)
  localparam logic [MODE_W-1:0] MODE_STEP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CUBIC  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KCNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CCNT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RST = MODE_LINEAR;
  localparam logic [KCNT_W-1:0] KCNT_RST = 7'd1;
  localparam logic [CCNT_W-1:0] CCNT_RST = 4'd3;

  // Sequencer step limits
  localparam logic [3:0] DIV_LAST   = 4'd15;
  localparam logic [3:0] COEF_LAST  = 4'd4;
  localparam logic [3:0] CUBIC_LAST = 4'd8;
  localparam logic [3:0] LIN_LAST   = 4'd1;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MOP_NONE, MOP_TT, MOP_T2T, MOP_HA, MOP_HB, MOP_HMO, MOP_HMI, MOP_RD, MOP_LIN
  } mop_t;

  // Result register updates
  typedef enum logic [3:0] {
    RACT_NONE, RACT_T2, RACT_T3, RACT_H, RACT_ACC, RACT_Y0, RACT_R, RACT_YADD,
    RACT_YLIN, RACT_YA
  } ract_t;

  // Word read captures
  typedef enum logic [2:0] {
    CAP_NONE, CAP_A, CAP_B, CAP_MO, CAP_MI
  } cap_t;

  typedef struct packed {
    logic              wr_time;
    logic              wr_word;
    logic              q_load;
    logic              t_rd;
    logic              t_cap_first;
    logic              t_cap_next;
    logic              k_load;
    logic              div_init;
    logic              div_step;
    logic              t_full;
    mop_t              mop;
    ract_t             ract;
    logic              w_rd;
    logic [SLOT_W-1:0] w_slot;
    logic              w_next;
    cap_t              cap;
    logic              out_load;
    logic              out_last;
  } kti_cmd_t;

  typedef struct packed {
    logic q_le_t;
    logic q_lt_t;
    logic num_le0;
    logic d_le0;
    logic num_ge_d;
  } kti_sts_t;

endpackage

FILE: rtl/kti_dp.sv
// Datapath of the keyframe track interpolator: key stores, segment
// arithmetic, restoring divider, shared multiplier and output register. Uses kti_pkg.
`timescale 1ns / 1ps
module kti_dp #(
  parameter int MAX_KEYS       = kti_pkg::MAX_KEYS_DEF,
  parameter int MAX_COMPONENTS = kti_pkg::MAX_COMPONENTS_DEF,
  localparam int KW  = $clog2(MAX_KEYS),
  localparam int CPW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
  input  logic                             clk,
  input  kti_pkg::kti_cmd_t                cmd,
  input  logic [KW-1:0]                    t_addr,
  input  logic [KW-1:0]                    k_val,
  input  logic [CPW-1:0]                   comp_idx,
  input  logic [kti_pkg::KEY_IDX_W-1:0]    in_key_index,
  input  logic [kti_pkg::SLOT_W-1:0]       in_slot,
  input  logic [kti_pkg::COMP_W-1:0]       in_component,
  input  logic signed [kti_pkg::DATA_W-1:0] in_data,
  output kti_pkg::kti_sts_t                sts,
  output logic [kti_pkg::COMP_W-1:0]       out_component,
  output logic signed [kti_pkg::DATA_W-1:0] out_value,
  output logic                             out_last
);
  import kti_pkg::*;

  localparam int WDEPTH = MAX_KEYS * WORD_SLOTS * MAX_COMPONENTS;
  localparam int WAW    = $clog2(WDEPTH);

  function automatic logic signed [51:0] rnd16(input logic signed [67:0] x);
    logic signed [67:0] s;
    s = x + 68'sd32768;
    return s[67:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    logic signed [31:0] r;
    if (v > 52'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -52'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  logic [DATA_W-1:0] tmem [MAX_KEYS];
  logic [DATA_W-1:0] wmem [WDEPTH];
  logic [DATA_W-1:0] rd_t_r, rd_w_r;

  logic signed [31:0] q_r, tk_r, tk1_r;
  logic [KW-1:0]      k_r;
  logic [33:0]        rem_r;
  logic [16:0]        t_r, t2_r, t3_r;
  logic signed [19:0] h00_r, h01_r, h10_r, h11_r;
  logic signed [31:0] a_r, b_r, mo_r, mi_r;
  logic signed [67:0] p_r, acc_r;
  logic signed [33:0] r_r;
  logic signed [51:0] y_r;
  logic [COMP_W-1:0]  out_component_r;
  logic signed [31:0] out_value_r;
  logic               out_last_r;

  logic signed [32:0] num, d, ba;
  logic [33:0]        rem2, d_u;
  logic               ge;
  logic signed [33:0] ma, mb;
  logic signed [19:0] t_s, t2_s, t3_s;
  logic signed [51:0] p_rnd;
  logic [KW-1:0]      kk;
  logic [WAW-1:0]     w_rd_addr, w_wr_addr;
  logic               time_wr_ok, word_wr_ok;

  // Segment quantities and status
  assign num = $signed({q_r[31], q_r}) - $signed({tk_r[31], tk_r});
  assign d   = $signed({tk1_r[31], tk1_r}) - $signed({tk_r[31], tk_r});
  assign ba  = $signed({b_r[31], b_r}) - $signed({a_r[31], a_r});
  assign sts.q_le_t   = q_r <= $signed(rd_t_r);
  assign sts.q_lt_t   = q_r < $signed(rd_t_r);
  assign sts.num_le0  = num <= 33'sd0;
  assign sts.d_le0    = d <= 33'sd0;
  assign sts.num_ge_d = num >= d;

  // Store addressing and write range checks
  assign time_wr_ok = 32'(in_key_index) < MAX_KEYS;
  assign word_wr_ok = time_wr_ok && (32'(in_slot) < WORD_SLOTS) &&
                      (32'(in_component) < MAX_COMPONENTS);
  assign w_wr_addr = (WAW'(in_key_index) * WAW'(WORD_SLOTS) + WAW'(in_slot)) *
                     WAW'(MAX_COMPONENTS) + WAW'(in_component);
  assign kk = cmd.w_next ? k_r + KW'(1) : k_r;
  assign w_rd_addr = (WAW'(kk) * WAW'(WORD_SLOTS) + WAW'(cmd.w_slot)) *
                     WAW'(MAX_COMPONENTS) + WAW'(comp_idx);

  // Key time store
  always_ff @(posedge clk) begin
    if (cmd.wr_time && time_wr_ok) tmem[KW'(in_key_index)] <= in_data;
    if (cmd.t_rd) rd_t_r <= tmem[t_addr];
  end

  // Key word store
  always_ff @(posedge clk) begin
    if (cmd.wr_word && word_wr_ok) wmem[w_wr_addr] <= in_data;
    if (cmd.w_rd) rd_w_r <= wmem[w_rd_addr];
  end

  // Divider step: one quotient bit per cycle
  assign rem2 = {rem_r[32:0], 1'b0};
  assign d_u  = {1'b0, d};
  assign ge   = rem2 >= d_u;

  // Multiplier operand select
  assign t_s  = $signed({3'b0, t_r});
  assign t2_s = $signed({3'b0, t2_r});
  assign t3_s = $signed({3'b0, t3_r});
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mop)
      MOP_TT:  begin ma = $signed({17'b0, t_r}); mb = $signed({17'b0, t_r}); end
      MOP_T2T: begin ma = $signed({17'b0, t2_r}); mb = $signed({17'b0, t_r}); end
      MOP_HA:  begin ma = {{14{h00_r[19]}}, h00_r}; mb = {{2{a_r[31]}}, a_r}; end
      MOP_HB:  begin ma = {{14{h01_r[19]}}, h01_r}; mb = {{2{b_r[31]}}, b_r}; end
      MOP_HMO: begin ma = {{14{h10_r[19]}}, h10_r}; mb = {{2{mo_r[31]}}, mo_r}; end
      MOP_HMI: begin ma = {{14{h11_r[19]}}, h11_r}; mb = {{2{mi_r[31]}}, mi_r}; end
      MOP_RD:  begin ma = r_r; mb = {d[32], d}; end
      MOP_LIN: begin ma = {ba[32], ba}; mb = $signed({17'b0, t_r}); end
      default: ;
    endcase
  end

  assign p_rnd = rnd16(p_r);

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.q_load) q_r <= in_data;
    if (cmd.t_cap_first) tk1_r <= rd_t_r;
    if (cmd.t_cap_next) begin
      tk_r  <= tk1_r;
      tk1_r <= rd_t_r;
    end
    if (cmd.k_load) k_r <= k_val;
    if (cmd.div_init) begin
      rem_r <= {1'b0, num};
      t_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem2 - d_u : rem2;
      t_r   <= {t_r[15:0], ge};
    end else if (cmd.t_full) begin
      t_r <= 17'(Q_ONE);
    end
    if (cmd.mop != MOP_NONE) p_r <= ma * mb;
    case (cmd.ract)
      RACT_T2:  t2_r <= p_rnd[16:0];
      RACT_T3:  t3_r <= p_rnd[16:0];
      RACT_H: begin
        h00_r <= (t3_s <<< 1) - (t2_s + (t2_s <<< 1)) + 20'sd65536;
        h10_r <= t3_s - (t2_s <<< 1) + t_s;
        h01_r <= (t2_s + (t2_s <<< 1)) - (t3_s <<< 1);
        h11_r <= t3_s - t2_s;
      end
      RACT_ACC:  acc_r <= p_r;
      RACT_Y0:   y_r <= rnd16(acc_r + p_r);
      RACT_R:    r_r <= p_rnd[33:0];
      RACT_YADD: y_r <= y_r + p_rnd;
      RACT_YLIN: y_r <= $signed({{20{a_r[31]}}, a_r}) + p_rnd;
      RACT_YA:   y_r <= $signed({{20{rd_w_r[31]}}, rd_w_r});
      default: ;
    endcase
    case (cmd.cap)
      CAP_A:  a_r  <= rd_w_r;
      CAP_B:  b_r  <= rd_w_r;
      CAP_MO: mo_r <= rd_w_r;
      CAP_MI: mi_r <= rd_w_r;
      default: ;
    endcase
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_component_r <= COMP_W'(comp_idx);
      out_value_r     <= sat32(y_r);
      out_last_r      <= cmd.out_last;
    end
  end

  assign out_component = out_component_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;

endmodule

FILE: rtl/kti_ctrl.sv
// Controller of the keyframe track interpolator: configuration registers,
// handshakes and the query sequencer. Uses kti_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "keyframe_track_interpolator_unit_macros.svh"
module kti_ctrl #(
  parameter int MAX_KEYS       = kti_pkg::MAX_KEYS_DEF,
  parameter int MAX_COMPONENTS = kti_pkg::MAX_COMPONENTS_DEF,
  localparam int KW  = $clog2(MAX_KEYS),
  localparam int CPW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kti_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  kti_pkg::kti_sts_t              sts,
  output kti_pkg::kti_cmd_t              cmd,
  output logic [KW-1:0]                  t_addr,
  output logic [KW-1:0]                  k_val,
  output logic [CPW-1:0]                 comp_idx
);
  import kti_pkg::*;

  localparam int NW  = $clog2(MAX_KEYS + 128);
  localparam int CCW = $clog2(MAX_COMPONENTS + 16);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_T0_RD  = 15'b000000000000010,
    ST_T0_CHK = 15'b000000000000100,
    ST_TS_RD  = 15'b000000000001000,
    ST_TS_CHK = 15'b000000000010000,
    ST_SEG    = 15'b000000000100000,
    ST_DIV    = 15'b000000001000000,
    ST_COEF   = 15'b000000010000000,
    ST_W_A    = 15'b000000100000000,
    ST_W_B    = 15'b000001000000000,
    ST_W_MO   = 15'b000010000000000,
    ST_W_MI   = 15'b000100000000000,
    ST_W_CAP  = 15'b001000000000000,
    ST_MUL    = 15'b010000000000000,
    ST_EMIT   = 15'b100000000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [KCNT_W-1:0] kcnt_r;
  logic [CCNT_W-1:0] ccnt_r;
  logic              hold_r, hold_nxt;
  logic [KW-1:0]     scan_r, scan_nxt;
  logic [CPW-1:0]    comp_r, comp_nxt;
  logic [3:0]        step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [NW-1:0]  n_w;
  logic [CCW-1:0] cc_w;
  logic           n_lt2, scan_end, comp_last, cubic, in_accept;

  // Effective key and component counts
  assign n_w   = (NW'(kcnt_r) > NW'(MAX_KEYS)) ? NW'(MAX_KEYS) : NW'(kcnt_r);
  assign cc_w  = (ccnt_r == '0) ? CCW'(1) :
                 (CCW'(ccnt_r) > CCW'(MAX_COMPONENTS)) ? CCW'(MAX_COMPONENTS) :
                 CCW'(ccnt_r);
  assign n_lt2     = n_w < NW'(2);
  assign scan_end  = (NW'(scan_r) + NW'(2)) == n_w;
  assign comp_last = (CCW'(comp_r) + CCW'(1)) == cc_w;
  assign cubic     = mode_r == MODE_CUBIC;

  assign in_ready  = state_r == ST_IDLE;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign t_addr    = (state_r == ST_TS_RD) ? scan_r + KW'(1) : '0;
  assign comp_idx  = comp_r;

  // Accept writes and sequence one query
  always_comb begin
    state_nxt = state_r;
    hold_nxt  = hold_r;
    scan_nxt  = scan_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    k_val     = '0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_WR_TIME: cmd.wr_time = 1'b1;
            OP_WR_WORD: cmd.wr_word = 1'b1;
            OP_QUERY: begin
              cmd.q_load = 1'b1;
              hold_nxt   = 1'b0;
              comp_nxt   = '0;
              state_nxt  = ST_T0_RD;
            end
            default: ;
          endcase
        end
      end
      ST_T0_RD: begin
        cmd.t_rd  = 1'b1;
        state_nxt = ST_T0_CHK;
      end
      ST_T0_CHK: begin
        cmd.t_cap_first = 1'b1;
        if (n_lt2 || sts.q_le_t) begin
          cmd.k_load = 1'b1;
          hold_nxt   = 1'b1;
          state_nxt  = ST_W_A;
        end else begin
          scan_nxt  = '0;
          state_nxt = ST_TS_RD;
        end
      end
      ST_TS_RD: begin
        cmd.t_rd  = 1'b1;
        state_nxt = ST_TS_CHK;
      end
      ST_TS_CHK: begin
        cmd.t_cap_next = 1'b1;
        if (sts.q_lt_t) begin
          cmd.k_load = 1'b1;
          k_val      = scan_r;
          state_nxt  = ST_SEG;
        end else if (scan_end) begin
          cmd.k_load = 1'b1;
          k_val      = KW'(n_w - NW'(1));
          hold_nxt   = 1'b1;
          state_nxt  = ST_W_A;
        end else begin
          scan_nxt  = scan_r + KW'(1);
          state_nxt = ST_TS_RD;
        end
      end
      ST_SEG: begin
        step_nxt = '0;
        if (mode_r == MODE_STEP || sts.num_le0 || sts.d_le0) begin
          hold_nxt  = 1'b1;
          state_nxt = ST_W_A;
        end else if (sts.num_ge_d) begin
          cmd.t_full = 1'b1;
          state_nxt  = cubic ? ST_COEF : ST_W_A;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = cubic ? ST_COEF : ST_W_A;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_COEF: begin
        case (step_r)
          4'd0: cmd.mop = MOP_TT;
          4'd1: cmd.ract = RACT_T2;
          4'd2: cmd.mop = MOP_T2T;
          4'd3: cmd.ract = RACT_T3;
          default: cmd.ract = RACT_H;
        endcase
        if (step_r == COEF_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_W_A;
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_W_A: begin
        cmd.w_rd   = 1'b1;
        cmd.w_slot = SLOT_VAL;
        state_nxt  = ST_W_B;
      end
      ST_W_B: begin
        cmd.cap = CAP_A;
        if (hold_r) begin
          cmd.ract  = RACT_YA;
          state_nxt = ST_EMIT;
        end else begin
          cmd.w_rd   = 1'b1;
          cmd.w_slot = SLOT_VAL;
          cmd.w_next = 1'b1;
          state_nxt  = ST_W_MO;
        end
      end
      ST_W_MO: begin
        cmd.cap  = CAP_B;
        step_nxt = '0;
        if (cubic) begin
          cmd.w_rd   = 1'b1;
          cmd.w_slot = SLOT_OUT;
          state_nxt  = ST_W_MI;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_W_MI: begin
        cmd.cap    = CAP_MO;
        cmd.w_rd   = 1'b1;
        cmd.w_slot = SLOT_IN;
        cmd.w_next = 1'b1;
        state_nxt  = ST_W_CAP;
      end
      ST_W_CAP: begin
        cmd.cap   = CAP_MI;
        step_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cubic) begin
          // Hermite terms through the shared multiplier
          case (step_r)
            4'd0: cmd.mop = MOP_HA;
            4'd1: begin cmd.ract = RACT_ACC; cmd.mop = MOP_HB; end
            4'd2: begin cmd.ract = RACT_Y0; cmd.mop = MOP_HMO; end
            4'd3: cmd.ract = RACT_R;
            4'd4: cmd.mop = MOP_RD;
            4'd5: begin cmd.ract = RACT_YADD; cmd.mop = MOP_HMI; end
            4'd6: cmd.ract = RACT_R;
            4'd7: cmd.mop = MOP_RD;
            default: cmd.ract = RACT_YADD;
          endcase
          if (step_r == CUBIC_LAST) state_nxt = ST_EMIT;
          else step_nxt = step_r + 4'd1;
        end else begin
          if (step_r == LIN_LAST) begin
            cmd.ract  = RACT_YLIN;
            state_nxt = ST_EMIT;
          end else begin
            cmd.mop  = MOP_LIN;
            step_nxt = step_r + 4'd1;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_last = comp_last;
          if (comp_last) begin
            state_nxt = ST_IDLE;
          end else begin
            comp_nxt  = comp_r + CPW'(1);
            state_nxt = ST_W_A;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold the output beat until taken
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_RST;
      kcnt_r      <= KCNT_RST;
      ccnt_r      <= CCNT_RST;
      hold_r      <= 1'b0;
      scan_r      <= '0;
      comp_r      <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
      scan_r      <= scan_nxt;
      comp_r      <= comp_nxt;
      step_r      <= step_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE: mode_r <= cfg_data[MODE_W-1:0];
          CFG_KCNT: kcnt_r <= cfg_data[KCNT_W-1:0];
          CFG_CCNT: ccnt_r <= cfg_data[CCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  `KTI_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_valid_r || out_ready)
  `KTI_ASSERT_NXT(a_query_scan, in_accept && (in_op == OP_QUERY), state_r == ST_T0_RD)
  `KTI_ASSERT_NXT(a_div_exit, (state_r == ST_DIV) && (step_r == DIV_LAST), (state_r == ST_COEF) || (state_r == ST_W_A))
  `KTI_ASSERT_IMP(a_comp_bound, state_r == ST_EMIT, CCW'(comp_r) < cc_w)

endmodule

FILE: rtl/keyframe_track_interpolator_unit.sv
// Keyframe track interpolator. A query scans the key times to find the segment,
// runs the fraction divider when needed, computes the cubic weights in cubic mode,
// then per component reads the key words and, for linear and cubic, works
// through one shared 34x34 multiplier and one read port.
// One item at a time; rst_n (synchronous, active low) clears control and config.
`timescale 1ns / 1ps
module keyframe_track_interpolator_unit #(
  parameter int MAX_KEYS       = kti_pkg::MAX_KEYS_DEF,
  parameter int MAX_COMPONENTS = kti_pkg::MAX_COMPONENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kti_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kti_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [kti_pkg::KEY_IDX_W-1:0]     in_key_index,
  input  logic [kti_pkg::SLOT_W-1:0]        in_slot,
  input  logic [kti_pkg::COMP_W-1:0]        in_component,
  input  logic signed [kti_pkg::DATA_W-1:0] in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kti_pkg::COMP_W-1:0]        out_component,
  output logic signed [kti_pkg::DATA_W-1:0] out_value,
  output logic                              out_last
);
  import kti_pkg::*;

  localparam int KW  = $clog2(MAX_KEYS);
  localparam int CPW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  kti_cmd_t       cmd;
  kti_sts_t       sts;
  logic [KW-1:0]  t_addr, k_val;
  logic [CPW-1:0] comp_idx;

  kti_ctrl #(
    .MAX_KEYS       (MAX_KEYS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .t_addr    (t_addr),
    .k_val     (k_val),
    .comp_idx  (comp_idx)
  );

  kti_dp #(
    .MAX_KEYS       (MAX_KEYS),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .t_addr        (t_addr),
    .k_val         (k_val),
    .comp_idx      (comp_idx),
    .in_key_index  (in_key_index),
    .in_slot       (in_slot),
    .in_component  (in_component),
    .in_data       (in_data),
    .sts           (sts),
    .out_component (out_component),
    .out_value     (out_value),
    .out_last      (out_last)
  );

endmodule
